// ----- rtl/ces_pkg.sv -----
// Shared constants, state encoding and control types for the COO entry sorter.
package ces_pkg;

    // Default sizing of the entry store and the payload fields.
    localparam int CES_MAX_ENTRIES = 64;
    localparam int CES_INDEX_BITS  = 10;
    localparam int CES_VALUE_BITS  = 32;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } ces_state_t;

    // Control from the sequencer to the shared selection unit.
    typedef struct packed {
        logic new_set;     // forget the previously emitted key
        logic clear_best;  // start a fresh minimum search
        logic cand_valid;  // a candidate from the store is present this cycle
        logic commit;      // the current best has been emitted
    } ces_sel_ctl_t;

endpackage

// ----- rtl/ces_entry_mem.sv -----
// Single-port-write, registered-read storage for the buffered coordinate entries.
module ces_entry_mem
    import ces_pkg::*;
#(
    parameter int DEPTH     = CES_MAX_ENTRIES,
    parameter int ADDR_BITS = $clog2(CES_MAX_ENTRIES),
    parameter int DATA_BITS = 2 * CES_INDEX_BITS + CES_VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/ces_select_unit.sv -----
// Shared compare unit that finds the next entry in row-major order, one candidate a cycle.
module ces_select_unit
    import ces_pkg::*;
#(
    parameter int INDEX_BITS = CES_INDEX_BITS,
    parameter int VALUE_BITS = CES_VALUE_BITS,
    parameter int ADDR_BITS  = $clog2(CES_MAX_ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ces_sel_ctl_t          ctl,
    input  logic [INDEX_BITS-1:0] cand_row,
    input  logic [INDEX_BITS-1:0] cand_col,
    input  logic [VALUE_BITS-1:0] cand_val,
    input  logic [ADDR_BITS-1:0]  cand_idx,
    output logic [INDEX_BITS-1:0] best_row,
    output logic [INDEX_BITS-1:0] best_col,
    output logic [VALUE_BITS-1:0] best_val
);

    // The slot number breaks ties, so equal coordinates leave in arrival order.
    localparam int KEY_BITS = 2 * INDEX_BITS + ADDR_BITS;

    logic                  best_found_reg;
    logic [KEY_BITS-1:0]   best_key_reg;
    logic [VALUE_BITS-1:0] best_val_reg;
    logic                  have_last_reg;
    logic [KEY_BITS-1:0]   last_key_reg;

    logic [KEY_BITS-1:0] cand_key;
    logic                above_last;
    logic                below_best;
    logic                take_cand;

    // A candidate wins if it follows the last emitted key and precedes the current best.
    always_comb
    begin
        cand_key   = {cand_row, cand_col, cand_idx};
        above_last = !have_last_reg || (cand_key > last_key_reg);
        below_best = !best_found_reg || (cand_key < best_key_reg);
        take_cand  = ctl.cand_valid && above_last && below_best;
    end

    // Search control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            have_last_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clear_best)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take_cand)
            begin
                best_found_reg <= 1'b1;
            end

            if (ctl.new_set)
            begin
                have_last_reg <= 1'b0;
            end
            else if (ctl.commit)
            begin
                have_last_reg <= 1'b1;
            end
        end
    end

    // Key and value payload.
    always_ff @(posedge clk)
    begin
        if (take_cand && !ctl.clear_best)
        begin
            best_key_reg <= cand_key;
            best_val_reg <= cand_val;
        end
        if (ctl.commit)
        begin
            last_key_reg <= best_key_reg;
        end
    end

    assign best_row = best_key_reg[KEY_BITS-1 -: INDEX_BITS];
    assign best_col = best_key_reg[KEY_BITS-INDEX_BITS-1 -: INDEX_BITS];
    assign best_val = best_val_reg;

endmodule

// ----- rtl/coo_entry_sorter_unit.sv -----
// While loading, entries are accepted back to back. After the final entry, each result
// comes from a scan that reads all n stored entries through the shared comparator, then
// a drain state, then an emit state that holds while the result side stalls.
// A single store read port feeds one comparator; loading resumes after the last result.
// Reset clears the sequencer, entry count and overflow flag; store contents stay undefined.
module coo_entry_sorter_unit
    import ces_pkg::*;
#(
    parameter int MAX_ENTRIES = CES_MAX_ENTRIES,
    parameter int INDEX_BITS  = CES_INDEX_BITS,
    parameter int VALUE_BITS  = CES_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         entry_valid,
    output logic                         entry_stall,
    input  logic [INDEX_BITS-1:0]        row_index,
    input  logic [INDEX_BITS-1:0]        col_index,
    input  logic signed [VALUE_BITS-1:0] entry_value,
    input  logic                         final_entry,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [INDEX_BITS-1:0]        out_row,
    output logic [INDEX_BITS-1:0]        out_col,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic                         out_last,
    output logic                         overflowed
);

    localparam int ADDR_BITS = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_BITS = 2 * INDEX_BITS + VALUE_BITS;

    ces_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 set_ovf_reg, set_ovf_next;
    logic [ADDR_BITS-1:0] scan_reg, scan_next;
    logic [CNT_BITS-1:0]  emit_reg, emit_next;
    logic                 cand_valid_reg;
    logic [ADDR_BITS-1:0] cand_idx_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic                 store_full;
    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [DATA_BITS-1:0] mem_rd_data;
    logic [CNT_BITS-1:0]  last_pos;
    ces_sel_ctl_t         sel_ctl;

    // The entry side is open only while loading, the result side only while emitting.
    assign in_fire    = entry_valid && (state_reg == ST_LOAD);
    assign out_fire   = (state_reg == ST_EMIT) && !result_stall;
    assign store_full = (count_reg == CNT_BITS'(MAX_ENTRIES));
    assign last_pos   = count_reg - CNT_BITS'(1);

    // Entry store.
    ces_entry_mem #(
        .DEPTH     (MAX_ENTRIES),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[ADDR_BITS-1:0]),
        .wr_data ({row_index, col_index, entry_value}),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_reg),
        .rd_data (mem_rd_data)
    );

    // Shared minimum search.
    ces_select_unit #(
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_sel (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sel_ctl),
        .cand_row (mem_rd_data[DATA_BITS-1 -: INDEX_BITS]),
        .cand_col (mem_rd_data[DATA_BITS-INDEX_BITS-1 -: INDEX_BITS]),
        .cand_val (mem_rd_data[VALUE_BITS-1:0]),
        .cand_idx (cand_idx_reg),
        .best_row (out_row),
        .best_col (out_col),
        .best_val (out_value)
    );

    // Sequencer state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            set_ovf_reg    <= 1'b0;
            scan_reg       <= '0;
            emit_reg       <= '0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            set_ovf_reg    <= set_ovf_next;
            scan_reg       <= scan_next;
            emit_reg       <= emit_next;
            cand_valid_reg <= mem_rd_en;
        end
    end

    // Slot number travels alongside the registered read.
    always_ff @(posedge clk)
    begin
        cand_idx_reg <= scan_reg;
    end

    // Next state and control outputs.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        set_ovf_next = set_ovf_reg;
        scan_next    = scan_reg;
        emit_next    = emit_reg;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;
        entry_stall  = 1'b1;
        result_valid = 1'b0;
        sel_ctl      = '0;
        sel_ctl.cand_valid = cand_valid_reg;

        case (state_reg)
            ST_LOAD:
            begin
                entry_stall = 1'b0;
                if (in_fire)
                begin
                    // Store the entry if there is room; otherwise note the drop.
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    if (final_entry)
                    begin
                        set_ovf_next       = ovf_reg || store_full;
                        scan_next          = '0;
                        emit_next          = '0;
                        sel_ctl.new_set    = 1'b1;
                        sel_ctl.clear_best = 1'b1;
                        state_next         = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // One store read per cycle over all stored slots.
                mem_rd_en = 1'b1;
                if (CNT_BITS'(scan_reg) == last_pos)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_BITS'(1);
                end
            end

            ST_DRAIN:
            begin
                // The last candidate is compared during this cycle.
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (out_fire)
                begin
                    sel_ctl.commit     = 1'b1;
                    sel_ctl.clear_best = 1'b1;
                    if (emit_reg == last_pos)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_next  = emit_reg + CNT_BITS'(1);
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_last   = (emit_reg == last_pos);
    assign overflowed = set_ovf_reg;

endmodule

// ----- rtl/ces_checker.sv -----
// Port-level checker for the COO entry sorter, bound to the top level.
module ces_checker
    import ces_pkg::*;
#(
    parameter int INDEX_BITS = CES_INDEX_BITS
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  entry_valid,
    input logic                  entry_stall,
    input logic                  final_entry,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [INDEX_BITS-1:0] out_row,
    input logic                  out_last
);

    // No new entry is taken while a sorted result is on offer.
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> entry_stall)
        else $error("entry channel open while a result is pending");

    // A final entry starts the sort, so the entry side closes right after it.
    a_final_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_valid && !entry_stall && final_entry) |=> entry_stall)
        else $error("entry channel still open after the final entry");

    // Every result but the last is followed by a search before the next one.
    a_rescan_between: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !out_last) |=> !result_valid)
        else $error("result offered without a new search");

    // Taking the last result reopens the entry side at once.
    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && out_last) |=> (!entry_stall && !result_valid))
        else $error("block did not return to loading after the last result");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(out_row)))
        else $error("stalled result changed");

endmodule

bind coo_entry_sorter_unit ces_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_ces_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry_valid  (entry_valid),
    .entry_stall  (entry_stall),
    .final_entry  (final_entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_row      (out_row),
    .out_last     (out_last)
);
